// ----- rtl/core/repf_pkg.sv -----
// Shared constants and register codes of the range edge point filter.
package repf_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_OFFSET = 16;
    localparam int DEF_COORD_BITS = 20;

    localparam int HEIGHT_LIMIT = 4096;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    localparam int MD_W   = 9;
    localparam int OFS_W  = 5;
    localparam int MINH_W = 16;
    localparam int FAC_W  = 17;
    localparam int GW_W   = 11;
    localparam int GH_W   = 13;

    localparam int FACTOR_ONE  = 65536;
    localparam int SCALE_SHIFT = 28;

    localparam logic [MD_W-1:0]          RST_MAX_DIST  = 9'd205;
    localparam logic [OFS_W-1:0]         RST_OFFSET    = 5'd1;
    localparam logic signed [MINH_W-1:0] RST_MIN_H     = 16'sd0;
    localparam logic [FAC_W-1:0]         RST_FACTOR    = 17'd65536;
    localparam logic [GW_W-1:0]          RST_GRID_W    = 11'd640;
    localparam logic [GH_W-1:0]          RST_GRID_H    = 13'd480;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_DIST     = 3'd0,
        REG_OFFSET       = 3'd1,
        REG_MIN_HEIGHT   = 3'd2,
        REG_RANGE_FACTOR = 3'd3,
        REG_GRID_WIDTH   = 3'd4,
        REG_GRID_HEIGHT  = 3'd5
    } cfg_reg_t;

endpackage

// ----- rtl/core/repf_ram.sv -----
// Generic simple dual-port RAM with registered read.
module repf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/core/range_edge_point_filter.sv -----
// Range edge point filter: removes points on range discontinuities of an organized grid.
//
// Usage:
//  - Points enter on the s_ stream in raster order, one transaction each; s_tuser is
//    the item kind (0 point, 1 drain). Drain transactions flush the last rows of a
//    frame once all rows have arrived; a drain sent earlier is swallowed.
//  - Results leave on the m_ stream, one per point, lagging the input by
//    neighbor_offset rows; m_tlast marks the last point of the frame.
//  - Registers are written on the cfg_ channel (always ready) while the block is idle;
//    the user must keep to this, the block itself does not enforce it.
//  - Throughput: one transaction per cycle, sustained while the output skid entry is
//    empty. The range square root is a pipeline of COORD_BITS stages (one root bit
//    each), followed by the line-store stage and three compare stages.
//  - Line stores: four copies of a (2*MAX_OFFSET+1) x MAX_WIDTH RAM, one read port
//    each (center, up, left, right); the down neighbor is the incoming point itself.
//  - Stall: the whole pipeline advances together while the output skid entry is
//    empty; m_tready low fills the skid entry and then drops s_tready, nothing lost.
//  - Reset clears control and the position counters and loads register defaults;
//    the line stores are not cleared and need no clearing pass.
module range_edge_point_filter #(
    parameter int MAX_WIDTH  = repf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_OFFSET = repf_pkg::DEF_MAX_OFFSET,
    parameter int COORD_BITS = repf_pkg::DEF_COORD_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [repf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [repf_pkg::CFG_DATA_W-1:0]      cfg_data,
    // input stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // point_x, point_y, point_z, point_valid (low to high), zero padded
    input  logic [((3*COORD_BITS+8)/8)*8-1:0]    s_tdata,
    // kind
    input  logic                                 s_tuser,
    // output stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // out_x, out_y, out_z, out_valid, edge_removed (low to high), zero padded
    output logic [((3*COORD_BITS+9)/8)*8-1:0]    m_tdata,
    // frame_last
    output logic                                 m_tlast
);

    import repf_pkg::*;

    localparam int CB       = COORD_BITS;
    localparam int LROWS    = 2 * MAX_OFFSET + 1;
    localparam int SLW      = $clog2(LROWS);
    localparam int CW       = $clog2(MAX_WIDTH);
    localparam int CCW      = $clog2(MAX_WIDTH + 1);
    localparam int RW       = $clog2(HEIGHT_LIMIT + MAX_OFFSET + 1);
    localparam int PW       = RW + 1;
    localparam int OW       = $clog2(MAX_OFFSET + 1);
    localparam int SQ_W     = 2 * CB;
    localparam int REM_W    = CB + 2;
    localparam int RAM_W    = 4 * CB + 1;
    localparam int DEPTH    = LROWS * (2 ** CW);
    localparam int AW       = SLW + CW;
    localparam int MW       = (CB > MINH_W ? CB : MINH_W) + 1;
    localparam int LW       = FAC_W + SQ_W;
    localparam int IN_BITS  = 3 * CB + 1;
    localparam int OUT_BITS = 3 * CB + 2;

    // stage map
    localparam int ST_IN    = 0;
    localparam int ST_SQ    = 1;
    localparam int ST_SUM   = 2;
    localparam int ST_ROOT0 = 3;
    localparam int ST_RAM   = ST_ROOT0 + CB;
    localparam int ST_DIFF  = ST_RAM + 1;
    localparam int ST_EXC   = ST_RAM + 2;
    localparam int ST_OUT   = ST_RAM + 3;
    localparam int NS       = ST_OUT + 1;

    typedef struct packed {
        logic                        has_res;
        logic                        wr;
        logic                        interior;
        logic                        same;
        logic                        last;
        logic signed [CB-1:0]        x;
        logic signed [CB-1:0]        y;
        logic signed [CB-1:0]        z;
        logic                        pv;
        logic [SLW-1:0]              wslot;
        logic [SLW-1:0]              cslot;
        logic [SLW-1:0]              uslot;
        logic [CW-1:0]               ccol;
        logic [CW-1:0]               lcol;
        logic [CW-1:0]               rcol;
        logic [SQ_W-2:0]             sqx;
        logic [SQ_W-2:0]             sqy;
        logic [SQ_W-2:0]             sqz;
        logic [SQ_W-1:0]             sum;
        logic [REM_W-1:0]            rem;
        logic [CB-1:0]               root;
        logic                        en;
        logic [3:0]                  nv;
        logic [3:0][CB-1:0]          dr;
        logic [3:0][SQ_W-1:0]        prod;
        logic [3:0]                  exc;
        logic                        removed;
    } item_t;

    typedef struct packed {
        logic signed [CB-1:0] x;
        logic signed [CB-1:0] y;
        logic signed [CB-1:0] z;
        logic                 ov;
        logic                 removed;
        logic                 last;
    } result_t;

    // ---------------------------------------------------------------- registers
    logic [MD_W-1:0]          md_reg;
    logic [OFS_W-1:0]         ofs_reg;
    logic signed [MINH_W-1:0] minh_reg;
    logic [FAC_W-1:0]         fac_reg;
    logic [GW_W-1:0]          gw_reg;
    logic [GH_W-1:0]          gh_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            md_reg   <= RST_MAX_DIST;
            ofs_reg  <= RST_OFFSET;
            minh_reg <= RST_MIN_H;
            fac_reg  <= RST_FACTOR;
            gw_reg   <= RST_GRID_W;
            gh_reg   <= RST_GRID_H;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_MAX_DIST:     md_reg   <= cfg_data[MD_W-1:0];
                REG_OFFSET:       ofs_reg  <= cfg_data[OFS_W-1:0];
                REG_MIN_HEIGHT:   minh_reg <= signed'(cfg_data[MINH_W-1:0]);
                REG_RANGE_FACTOR: fac_reg  <= cfg_data[FAC_W-1:0];
                REG_GRID_WIDTH:   gw_reg   <= cfg_data[GW_W-1:0];
                REG_GRID_HEIGHT:  gh_reg   <= cfg_data[GH_W-1:0];
                default:          ;
            endcase
        end
    end

    // saturated working values
    logic [OW-1:0]    off_eff;
    logic [PW-1:0]    off_p;
    logic [PW-1:0]    w_eff;
    logic [PW-1:0]    h_eff;
    logic [FAC_W-1:0] fac_eff;

    always_comb
    begin
        if (32'(ofs_reg) > MAX_OFFSET)
            off_eff = OW'(MAX_OFFSET);
        else
            off_eff = OW'(ofs_reg);
        off_p = PW'(off_eff);

        if (gw_reg < GW_W'(2))
            w_eff = PW'(2);
        else if (32'(gw_reg) > MAX_WIDTH)
            w_eff = PW'(MAX_WIDTH);
        else
            w_eff = PW'(gw_reg);

        if (gh_reg < GH_W'(2))
            h_eff = PW'(2);
        else if (32'(gh_reg) > HEIGHT_LIMIT)
            h_eff = PW'(HEIGHT_LIMIT);
        else
            h_eff = PW'(gh_reg);

        if (32'(fac_reg) > FACTOR_ONE)
            fac_eff = FAC_W'(FACTOR_ONE);
        else
            fac_eff = fac_reg;
    end

    // ---------------------------------------------------------------- position
    function automatic logic [SLW-1:0] slot_inc(input logic [SLW-1:0] s);
        if (32'(s) == LROWS - 1)
            return '0;
        return s + SLW'(1);
    endfunction

    function automatic logic [SLW-1:0] slot_sub(input logic [SLW-1:0] s,
                                                 input logic [SLW-1:0] d);
        if (s >= d)
            return s - d;
        return SLW'((SLW+1)'(s) + (SLW+1)'(LROWS) - (SLW+1)'(d));
    endfunction

    logic [CCW-1:0] col_reg;
    logic [RW-1:0]  row_reg;
    logic [SLW-1:0] slot_reg;

    logic           adv;
    logic           in_acc;
    logic           ignore;
    logic           vin;
    item_t          in_item;
    logic [PW-1:0]  c0, r0, c1, r1, e;
    logic [SLW-1:0] s0, s1, off_s;
    logic           drain;

    always_comb
    begin
        c0    = PW'(col_reg);
        r0    = PW'(row_reg);
        s0    = slot_reg;
        off_s = SLW'(off_eff);
        drain = s_tuser;

        // wrap a position left over from a geometry change
        if (c0 >= w_eff)
        begin
            c0 = '0;
            r0 = r0 + PW'(1);
            s0 = slot_inc(s0);
        end
        if (r0 >= h_eff + off_p)
        begin
            r0 = '0;
            s0 = '0;
        end

        ignore = drain && (r0 < h_eff);

        // a point during the drain rows starts a new frame
        if (!drain && (r0 >= h_eff))
        begin
            r0 = '0;
            c0 = '0;
            s0 = '0;
        end

        e = r0 - off_p;

        in_item          = '0;
        in_item.has_res  = (r0 >= off_p);
        in_item.wr       = !drain;
        in_item.interior = (e >= off_p) && (e + off_p < h_eff) &&
                           (c0 >= off_p) && (c0 + off_p < w_eff);
        in_item.same     = (off_eff == '0);
        in_item.last     = (e == h_eff - PW'(1)) && (c0 == w_eff - PW'(1));
        in_item.x        = signed'(s_tdata[CB-1:0]);
        in_item.y        = signed'(s_tdata[2*CB-1:CB]);
        in_item.z        = signed'(s_tdata[3*CB-1:2*CB]);
        in_item.pv       = s_tdata[3*CB];
        in_item.wslot    = s0;
        in_item.cslot    = slot_sub(s0, off_s);
        in_item.uslot    = slot_sub(s0, SLW'({off_s, 1'b0}));
        in_item.ccol     = CW'(c0);
        in_item.lcol     = CW'(c0 - off_p);
        in_item.rcol     = CW'(c0 + off_p);

        c1 = c0 + PW'(1);
        r1 = r0;
        s1 = s0;
        if (c1 >= w_eff)
        begin
            c1 = '0;
            r1 = r0 + PW'(1);
            s1 = slot_inc(s0);
            if (r1 >= h_eff + off_p)
            begin
                r1 = '0;
                s1 = '0;
            end
        end
    end

    assign in_acc = s_tvalid && s_tready;
    assign vin    = in_acc && !ignore;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            slot_reg <= '0;
        end
        else if (in_acc)
        begin
            if (ignore)
            begin
                col_reg  <= CCW'(c0);
                row_reg  <= RW'(r0);
                slot_reg <= s0;
            end
            else
            begin
                col_reg  <= CCW'(c1);
                row_reg  <= RW'(r1);
                slot_reg <= s1;
            end
        end
    end

    // ---------------------------------------------------------------- line stores
    item_t              pipe_reg [NS];
    item_t              pipe_next [NS];
    logic [NS-1:0]      v_reg;
    logic [3:0][RAM_W-1:0] rd;
    logic [3:0][AW-1:0]    raddr;
    logic [AW-1:0]      waddr;
    logic [RAM_W-1:0]   wdata;
    logic               we;

    assign waddr = {pipe_reg[ST_RAM-1].wslot, pipe_reg[ST_RAM-1].ccol};
    assign wdata = {pipe_reg[ST_RAM-1].root, pipe_reg[ST_RAM-1].pv, pipe_reg[ST_RAM-1].z,
                    pipe_reg[ST_RAM-1].y, pipe_reg[ST_RAM-1].x};
    assign we    = adv && v_reg[ST_RAM-1] && pipe_reg[ST_RAM-1].wr;

    // port 0 center, 1 up, 2 left, 3 right
    assign raddr[0] = {pipe_reg[ST_RAM-1].cslot, pipe_reg[ST_RAM-1].ccol};
    assign raddr[1] = {pipe_reg[ST_RAM-1].uslot, pipe_reg[ST_RAM-1].ccol};
    assign raddr[2] = {pipe_reg[ST_RAM-1].cslot, pipe_reg[ST_RAM-1].lcol};
    assign raddr[3] = {pipe_reg[ST_RAM-1].cslot, pipe_reg[ST_RAM-1].rcol};

    for (genvar k = 0; k < 4; k++)
    begin : g_line
        repf_ram #(
            .WIDTH (RAM_W),
            .DEPTH (DEPTH)
        ) u_line (
            .clk   (clk),
            .we    (we),
            .waddr (waddr),
            .wdata (wdata),
            .re    (adv),
            .raddr (raddr[k]),
            .rdata (rd[k])
        );
    end

    // ---------------------------------------------------------------- pipeline
    always_comb
    begin
        logic [REM_W+1:0]      t;
        logic [REM_W+1:0]      trial;
        logic [RAM_W-1:0]      selfw;
        logic [RAM_W-1:0]      cw;
        logic [3:0][RAM_W-1:0] nw;
        logic [CB-1:0]         rc;
        logic [CB-1:0]         rn;
        logic signed [MW-1:0]  zc_ext;
        logic signed [MW-1:0]  mh_ext;
        logic signed [SQ_W-1:0] sq;
        logic [LW-1:0]         lim;

        pipe_next[ST_IN] = in_item;
        lim = LW'(md_reg) << SCALE_SHIFT;

        for (int i = 1; i < NS; i++)
        begin
            pipe_next[i] = pipe_reg[i-1];

            if (i == ST_SQ)
            begin
                sq = pipe_reg[i-1].x * pipe_reg[i-1].x;
                pipe_next[i].sqx = sq[SQ_W-2:0];
                sq = pipe_reg[i-1].y * pipe_reg[i-1].y;
                pipe_next[i].sqy = sq[SQ_W-2:0];
                sq = pipe_reg[i-1].z * pipe_reg[i-1].z;
                pipe_next[i].sqz = sq[SQ_W-2:0];
            end
            else if (i == ST_SUM)
            begin
                pipe_next[i].sum  = SQ_W'(pipe_reg[i-1].sqx) + SQ_W'(pipe_reg[i-1].sqy) +
                                    SQ_W'(pipe_reg[i-1].sqz);
                pipe_next[i].rem  = '0;
                pipe_next[i].root = '0;
            end
            else if (i >= ST_ROOT0 && i < ST_RAM)
            begin
                // one root bit per stage
                t     = {pipe_reg[i-1].rem, pipe_reg[i-1].sum[SQ_W-1 -: 2]};
                trial = (REM_W+2)'({pipe_reg[i-1].root, 2'b01});
                if (t >= trial)
                begin
                    pipe_next[i].rem  = REM_W'(t - trial);
                    pipe_next[i].root = {pipe_reg[i-1].root[CB-2:0], 1'b1};
                end
                else
                begin
                    pipe_next[i].rem  = REM_W'(t);
                    pipe_next[i].root = {pipe_reg[i-1].root[CB-2:0], 1'b0};
                end
                pipe_next[i].sum = pipe_reg[i-1].sum << 2;
            end
            else if (i == ST_DIFF)
            begin
                selfw = {pipe_reg[i-1].root, pipe_reg[i-1].pv, pipe_reg[i-1].z,
                         pipe_reg[i-1].y, pipe_reg[i-1].x};
                // zero offset: the center is the point itself
                cw    = pipe_reg[i-1].same ? selfw : rd[0];
                nw[0] = rd[1];
                nw[1] = selfw;
                nw[2] = rd[2];
                nw[3] = rd[3];

                pipe_next[i].x  = signed'(cw[CB-1:0]);
                pipe_next[i].y  = signed'(cw[2*CB-1:CB]);
                pipe_next[i].z  = signed'(cw[3*CB-1:2*CB]);
                pipe_next[i].pv = cw[3*CB];
                rc = cw[4*CB:3*CB+1];

                zc_ext = MW'(signed'(cw[3*CB-1:2*CB]));
                mh_ext = MW'(minh_reg);
                pipe_next[i].en = (md_reg != '0) && cw[3*CB] && (zc_ext >= mh_ext) &&
                                  pipe_reg[i-1].interior && !pipe_reg[i-1].same;

                for (int k = 0; k < 4; k++)
                begin
                    rn = nw[k][4*CB:3*CB+1];
                    pipe_next[i].nv[k]   = nw[k][3*CB];
                    pipe_next[i].dr[k]   = (rn > rc) ? rn - rc : rc - rn;
                    pipe_next[i].prod[k] = SQ_W'(rc) * SQ_W'(pipe_next[i].dr[k]);
                end
            end
            else if (i == ST_EXC)
            begin
                for (int k = 0; k < 4; k++)
                begin
                    if (fac_eff == '0)
                        pipe_next[i].exc[k] = (pipe_reg[i-1].dr[k] > CB'(md_reg));
                    else
                        pipe_next[i].exc[k] =
                            (LW'(fac_eff) * LW'(pipe_reg[i-1].prod[k])) > lim;
                end
            end
            else if (i == ST_OUT)
            begin
                pipe_next[i].removed = pipe_reg[i-1].en &&
                                       (&(~pipe_reg[i-1].nv | pipe_reg[i-1].exc));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[NS-2:0], vin};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < NS; i++)
            begin
                pipe_reg[i] <= pipe_next[i];
            end
        end
    end

    // ---------------------------------------------------------------- output + skid
    result_t out_reg;
    result_t skid_reg;
    result_t res_new;
    logic    out_v_reg;
    logic    skid_v_reg;
    logic    push;
    logic    pop;

    assign adv      = !skid_v_reg;
    assign s_tready = !skid_v_reg;
    assign push     = adv && v_reg[ST_OUT] && pipe_reg[ST_OUT].has_res;
    assign pop      = out_v_reg && m_tready;

    always_comb
    begin
        res_new.x       = pipe_reg[ST_OUT].x;
        res_new.y       = pipe_reg[ST_OUT].y;
        res_new.z       = pipe_reg[ST_OUT].z;
        res_new.ov      = pipe_reg[ST_OUT].pv && !pipe_reg[ST_OUT].removed;
        res_new.removed = pipe_reg[ST_OUT].removed;
        res_new.last    = pipe_reg[ST_OUT].last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (pop)
        begin
            if (skid_v_reg)
            begin
                skid_v_reg <= 1'b0;
            end
            else
            begin
                out_v_reg <= push;
            end
        end
        else if (push)
        begin
            if (out_v_reg)
                skid_v_reg <= 1'b1;
            else
                out_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (skid_v_reg)
                out_reg <= skid_reg;
            else if (push)
                out_reg <= res_new;
        end
        else if (push)
        begin
            if (out_v_reg)
                skid_reg <= res_new;
            else
                out_reg <= res_new;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tlast  = out_reg.last;

    always_comb
    begin
        m_tdata = '0;
        m_tdata[OUT_BITS-1:0] = {out_reg.removed, out_reg.ov, out_reg.z, out_reg.y, out_reg.x};
    end

endmodule

// ----- rtl/core/repf_checker.sv -----
// Port-level checks of the range edge point filter, bound to the top level.
module repf_checker #(
    parameter int COORD_BITS = repf_pkg::DEF_COORD_BITS
) (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [((3*COORD_BITS+9)/8)*8-1:0] m_tdata,
    input logic                              m_tlast
);

    import repf_pkg::*;

    localparam int VB = 3 * COORD_BITS;

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // a removed point never reads as valid
    a_removed: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[VB+1] && m_tdata[VB]))
        else $error("removed point flagged valid");

    // input backpressure only while a result waits
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with empty output");

    // leaving reset: empty output, ready input
    a_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> !m_tvalid && s_tready)
        else $error("state not cleared by reset");

endmodule

bind range_edge_point_filter repf_checker #(
    .COORD_BITS (COORD_BITS)
) u_repf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// ----- tb/tb.sv -----
// Self-checking testbench of the range edge point filter, with its scoreboard.
`timescale 1ns / 100ps

import repf_pkg::*;

// Scoreboard: mirrors the filter's line stores and counters and queues the
// expected result that each accepted transaction completes.
class repf_scoreboard;

    localparam int LROWS = 2 * DEF_MAX_OFFSET + 1;
    localparam int CB    = DEF_COORD_BITS;

    typedef struct {
        logic [CB-1:0] x;
        logic [CB-1:0] y;
        logic [CB-1:0] z;
        bit            valid;
        bit            removed;
        bit            last;
    } filtered_point_t;

    bit [CB-1:0]  line_x [0:LROWS*DEF_MAX_WIDTH-1];
    bit [CB-1:0]  line_y [0:LROWS*DEF_MAX_WIDTH-1];
    bit [CB-1:0]  line_z [0:LROWS*DEF_MAX_WIDTH-1];
    bit           line_v [0:LROWS*DEF_MAX_WIDTH-1];
    int unsigned  line_r [0:LROWS*DEF_MAX_WIDTH-1];

    int unsigned max_dist, nb_ofs, factor, width, height, col, row;
    int          min_h;

    filtered_point_t pending_points[$];
    int errors, n_points, n_drains, n_results, n_removed;

    function void reset_state();
        col      = 0;
        row      = 0;
        max_dist = RST_MAX_DIST;
        nb_ofs   = RST_OFFSET;
        min_h    = RST_MIN_H;
        factor   = RST_FACTOR;
        width    = RST_GRID_W;
        height   = RST_GRID_H;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] v);
        case (idx)
            REG_MAX_DIST:     max_dist = v[MD_W-1:0];
            REG_OFFSET:       nb_ofs   = v[OFS_W-1:0];
            REG_MIN_HEIGHT:   min_h    = $signed(v[MINH_W-1:0]);
            REG_RANGE_FACTOR: factor   = v[FAC_W-1:0];
            REG_GRID_WIDTH:   width    = v[GW_W-1:0];
            REG_GRID_HEIGHT:  height   = v[GH_W-1:0];
            default: ;
        endcase
    endfunction

    function int unsigned eff_offset();
        return nb_ofs > DEF_MAX_OFFSET ? DEF_MAX_OFFSET : nb_ofs;
    endfunction

    static function longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b   = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    static function int loc(int unsigned r, int unsigned c);
        return (r % LROWS) * DEF_MAX_WIDTH + (c % DEF_MAX_WIDTH);
    endfunction

    // scaled range step to one neighbor above threshold
    function bit steep(int unsigned rc, int unsigned rn, int unsigned f);
        longint unsigned dr, lim, p;
        dr  = rn > rc ? rn - rc : rc - rn;
        lim = longint'(max_dist) << SCALE_SHIFT;
        if (f == 0)
            return dr > max_dist;
        p = longint'(rc) * dr;
        if (p > lim)
            return 1;
        return longint'(f) * p > lim;
    endfunction

    function void note_input(bit drain, bit [CB-1:0] x, bit [CB-1:0] y, bit [CB-1:0] z,
                             bit v);
        int unsigned ofs, w, h, f, e, c, rc;
        int a;
        longint sx, sy, sz;
        bit removed;
        filtered_point_t res;
        int nb[4];
        ofs = eff_offset();
        w   = width < 2 ? 2 : (width > DEF_MAX_WIDTH ? DEF_MAX_WIDTH : width);
        h   = height < 2 ? 2 : (height > HEIGHT_LIMIT ? HEIGHT_LIMIT : height);
        f   = factor > FACTOR_ONE ? FACTOR_ONE : factor;
        if (col >= w)
        begin
            col = 0;
            row++;
        end
        if (row >= h + ofs)
            row = 0;
        if (drain)
        begin
            n_drains++;
            if (row < h)
                return;
        end
        else
        begin
            n_points++;
            if (row >= h)
            begin
                row = 0;
                col = 0;
            end
            a = loc(row, col);
            line_x[a] = x;
            line_y[a] = y;
            line_z[a] = z;
            line_v[a] = v;
            sx = $signed(x);
            sy = $signed(y);
            sz = $signed(z);
            line_r[a] = int_sqrt(sx * sx + sy * sy + sz * sz);
        end
        if (row >= ofs)
        begin
            e = row - ofs;
            c = col;
            a = loc(e, c);
            removed = 0;
            if (max_dist != 0 && line_v[a] && longint'($signed(line_z[a])) >= min_h &&
                e >= ofs && e + ofs < h && c >= ofs && c + ofs < w)
            begin
                rc = line_r[a];
                nb[0] = loc(e - ofs, c);
                nb[1] = loc(e + ofs, c);
                nb[2] = loc(e, c - ofs);
                nb[3] = loc(e, c + ofs);
                removed = 1;
                foreach (nb[i])
                    if (line_v[nb[i]] && !steep(rc, line_r[nb[i]], f))
                        removed = 0;
            end
            res.x       = line_x[a];
            res.y       = line_y[a];
            res.z       = line_z[a];
            res.valid   = line_v[a] && !removed;
            res.removed = removed;
            res.last    = (e == h - 1) && (c == w - 1);
            pending_points.push_back(res);
        end
        col++;
        if (col >= w)
        begin
            col = 0;
            row++;
            if (row >= h + ofs)
                row = 0;
        end
    endfunction

    function void check_result(logic [63:0] d, logic last);
        filtered_point_t exp_pt;
        if (pending_points.size() == 0)
        begin
            $error("unexpected output transaction, data %h", d);
            errors++;
            return;
        end
        exp_pt = pending_points.pop_front();
        n_results++;
        if (exp_pt.removed)
            n_removed++;
        if (d[19:0] !== exp_pt.x)
        begin
            $error("out_x expected %h actual %h", exp_pt.x, d[19:0]);
            errors++;
        end
        if (d[39:20] !== exp_pt.y)
        begin
            $error("out_y expected %h actual %h", exp_pt.y, d[39:20]);
            errors++;
        end
        if (d[59:40] !== exp_pt.z)
        begin
            $error("out_z expected %h actual %h", exp_pt.z, d[59:40]);
            errors++;
        end
        if (d[60] !== exp_pt.valid)
        begin
            $error("out_valid expected %0d actual %b", exp_pt.valid, d[60]);
            errors++;
        end
        if (d[61] !== exp_pt.removed)
        begin
            $error("edge_removed expected %0d actual %b", exp_pt.removed, d[61]);
            errors++;
        end
        if (last !== exp_pt.last)
        begin
            $error("frame_last expected %0d actual %b", exp_pt.last, last);
            errors++;
        end
    endfunction

endclass

module tb;

    localparam int SETTLE_CYCLES = 60;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [63:0]           s_tdata;   // point_x, point_y, point_z, point_valid
    logic                  s_tuser;   // kind
    logic                  m_tvalid;
    logic                  m_tready;
    logic [63:0]           m_tdata;   // out_x, out_y, out_z, out_valid, edge_removed
    logic                  m_tlast;   // frame_last

    repf_scoreboard sb;

    bit fast_mode;      // no gaps on either side
    bit hold_req;       // ask the receiver for a long hold-off
    int base_range;     // typical point range of the current frame
    int n_frames;

    range_edge_point_filter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    // hard limit on the run
    initial
    begin
        #200_000_000;
        $display("tb failed");
        $finish;
    end

    // receiver: random back-pressure, occasional long hold-off on request
    initial
    begin
        int stall;
        stall = 0;
        m_tready = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 0;
                stall    = 400;
            end
            if (stall > 0)
            begin
                stall--;
                m_tready <= 0;
            end
            else if (fast_mode)
                m_tready <= 1;
            else if ($urandom_range(0, 299) == 0)
            begin
                stall    = $urandom_range(20, 60);
                m_tready <= 0;
            end
            else
                m_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    // output monitor: values sampled before this edge's updates
    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tlast);

    function automatic int pick_gap();
        int r;
        if (fast_mode)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_item(bit drain, bit [19:0] x, bit [19:0] y, bit [19:0] z, bit v);
        int gap;
        s_tvalid <= 1;
        s_tuser  <= drain;
        s_tdata  <= {3'b000, v, z, y, x};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_input(drain, x, y, z, v);
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_drain();
        send_item(1, $urandom, $urandom, $urandom, $urandom);
    endtask

    // sender pause until every expected transaction is out, then let drains settle
    task automatic wait_idle();
        while (sb.pending_points.size() != 0)
            @(posedge clk);
        s_tvalid <= 0;
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, int unsigned v);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_reg(idx, v);
        cfg_valid <= 0;
    endtask

    task automatic set_all(int md, int ofs, int mh, int fac, int w, int h);
        wait_idle();
        write_reg(REG_MAX_DIST, md);
        write_reg(REG_OFFSET, ofs);
        write_reg(REG_MIN_HEIGHT, mh & 16'hFFFF);
        write_reg(REG_RANGE_FACTOR, fac);
        write_reg(REG_GRID_WIDTH, w);
        write_reg(REG_GRID_HEIGHT, h);
    endtask

    // point near the frame's base range, with noise and occasional jumps
    task automatic send_random_point();
        int r, rx;
        r = $urandom_range(0, 99);
        if (r < 3)
            send_item(0, $urandom, $urandom, $urandom, $urandom);
        else
        begin
            rx = (r < 15) ? base_range + $urandom_range(0, 6000) - 3000
                          : base_range + $urandom_range(0, 80) - 40;
            if ($urandom_range(0, 1))
                rx = -rx;
            send_item(0, rx, $urandom_range(0, 4000) - 2000,
                      $urandom_range(0, 6000) - 3000, r >= 10);
        end
    endtask

    // one frame in raster order, then its drain; cut stops the drain early
    task automatic run_frame(bit cut);
        int unsigned w, h, ofs, ndrain;
        w   = sb.width < 2 ? 2 : (sb.width > DEF_MAX_WIDTH ? DEF_MAX_WIDTH : sb.width);
        h   = sb.height < 2 ? 2 : (sb.height > HEIGHT_LIMIT ? HEIGHT_LIMIT : sb.height);
        ofs = sb.eff_offset();
        base_range = $urandom_range(4096, 40000);
        for (int unsigned i = 0; i < w * h; i++)
        begin
            send_random_point();
            // a drain while rows still arrive is swallowed
            if (i + 1 < w * h && $urandom_range(0, 99) == 0)
                send_drain();
        end
        ndrain = cut ? $urandom_range(0, ofs * w - 1) : ofs * w;
        repeat (ndrain) send_drain();
        n_frames++;
    endtask

    initial
    begin
        int rnd_total;
        bit [19:0] dx, dy, dz;
        bit dv;
        sb = new();
        sb.reset_state();
        rst_n     = 0;
        cfg_valid = 0;
        cfg_index = REG_MAX_DIST;
        cfg_data  = 0;
        s_tvalid  = 0;
        s_tdata   = 0;
        s_tuser   = 0;
        fast_mode = 0;
        hold_req  = 0;
        n_frames  = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed 5x5 frame: extremes, invalids, removed and kept edges
        set_all(205, 1, 0, FACTOR_ONE, 5, 5);
        send_drain();
        for (int i = 0; i < 25; i++)
        begin
            dx = 16384;
            dy = 0;
            dz = 0;
            dv = 1;
            case (i)
                0:  begin dx = 20'h80000; dy = 20'h80000; dz = 20'h80000; end
                4:  begin dx = 20'h7FFFF; dy = 20'h7FFFF; dz = 20'h7FFFF; end
                6:  dx = 20000;                         // steep step, removed
                8:  begin dx = 20000; dz = -100; end    // below min height, kept
                18: dx = 16400;                         // gentle step, kept
                7, 11, 13, 17, 24: dv = 0;              // center 12 has no valid neighbor
                default: ;
            endcase
            send_item(0, dx, dy, dz, dv);
        end
        repeat (5) send_drain();
        send_drain();
        n_frames++;

        // long receiver hold-off while the sender keeps pushing
        set_all(205, 2, 0, FACTOR_ONE, 12, 10);
        fast_mode = 1;
        hold_req  = 1;
        run_frame(0);
        fast_mode = 0;

        // geometry and register extremes
        set_all(410, 1, -20480, 0, 1024, 2);
        run_frame(0);
        set_all(0, 1, 20480, FACTOR_ONE, 2, 4096);
        run_frame(0);
        set_all(100, 16, 0, 40000, 33, 34);
        run_frame(0);
        set_all(300, 31, -20480, 131071, 33, 33);
        run_frame(0);
        set_all(60, 3, 20480, 0, 0, 1);
        run_frame(0);

        // random settings, mostly small frames
        rnd_total = sb.n_points + 2000;
        while (sb.n_points < rnd_total)
        begin
            int unsigned ofs, nfr;
            ofs = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 3);
            set_all(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, 410), ofs,
                    $urandom_range(0, 40960) - 20480,
                    ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, FACTOR_ONE),
                    $urandom_range(2, 2 * ofs + 8), $urandom_range(2, 2 * ofs + 8));
            fast_mode = ($urandom_range(0, 4) == 0);
            nfr = $urandom_range(1, 3);
            for (int unsigned k = 0; k < nfr; k++)
                run_frame(k + 1 < nfr && $urandom_range(0, 5) == 0);
            fast_mode = 0;
        end

        wait_idle();
        $display("covered %0d points and %0d drain transactions in %0d frames",
                 sb.n_points, sb.n_drains, n_frames);
        $display("checked %0d results, %0d of them removed as edges",
                 sb.n_results, sb.n_removed);
        if (sb.errors == 0 && sb.pending_points.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
